### rtl/rrsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsd_pkg: shared types and constants
// Command codes, result kinds, register indexes and the queue entry format
// used by the RGB run-length span decoder.
// ----------------------------------------------------------------------------
package rrsd_pkg;

  // Stream byte limit and the saturation point of the byte counter.
  localparam int unsigned MAX_STREAM_BYTES = 10000;
  localparam int unsigned INDEX_W          = 14;
  localparam logic [INDEX_W-1:0] INDEX_CAP = {INDEX_W{1'b1}};
  localparam logic [INDEX_W-1:0] INDEX_MAX = INDEX_W'(MAX_STREAM_BYTES);

  // Command queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Result kinds.
  localparam logic [1:0] KIND_SPAN     = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_LIMIT    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_FADE_RED      = 3'd0;
  localparam logic [2:0] REG_FADE_GREEN    = 3'd1;
  localparam logic [2:0] REG_FADE_BLUE     = 3'd2;
  localparam logic [2:0] REG_START_X       = 3'd3;
  localparam logic [2:0] REG_START_Y       = 3'd4;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd6;

  // Commands passed from the parser to the span engine.
  typedef enum logic [1:0] {
    CMD_HEADER  = 2'd0,
    CMD_ROW_END = 2'd1,
    CMD_SPAN    = 2'd2,
    CMD_LIMIT   = 2'd3
  } cmd_t;

  // One queue entry: a classified four-byte record.
  typedef struct packed {
    cmd_t        cmd;
    logic        done;    // image complete after this command
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [15:0] row;
  } entry_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]         fade_red;
    logic [7:0]         fade_green;
    logic [7:0]         fade_blue;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [11:0]        screen_width;
    logic [11:0]        screen_height;
  } cfg_t;

endpackage

### rtl/rrsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsd_front: stream parser
// Gathers bytes into four-byte groups, tracks header, row count, byte limit
// and completion, and pushes one command per meaningful group.
// ----------------------------------------------------------------------------
module rrsd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            new_image,
  output logic            push,
  output rrsd_pkg::entry_t push_entry
);
  import rrsd_pkg::*;

  logic [1:0]         byte_phase, byte_phase_next;
  logic               in_header, in_header_next;
  logic [23:0]        held_bytes, held_bytes_next;
  logic [15:0]        image_height, image_height_next;
  logic [15:0]        row, row_next;
  logic [INDEX_W-1:0] byte_index, byte_index_next;
  logic               finished, finished_next;

  // Values after an optional restart on the first byte of a new image.
  logic [1:0]         cur_phase;
  logic               cur_header;
  logic [23:0]        cur_held;
  logic [15:0]        cur_height;
  logic [15:0]        cur_row;
  logic [INDEX_W-1:0] cur_index;
  logic               cur_finished;
  logic [15:0]        row_inc;
  logic [15:0]        new_height;

  always_comb begin
    cur_phase    = new_image ? 2'd0 : byte_phase;
    cur_header   = new_image ? 1'b1 : in_header;
    cur_held     = new_image ? 24'd0 : held_bytes;
    cur_height   = new_image ? 16'd0 : image_height;
    cur_row      = new_image ? 16'd0 : row;
    cur_index    = new_image ? '0 : byte_index;
    cur_finished = new_image ? 1'b0 : finished;
    row_inc      = cur_row + 16'd1;
    new_height   = {cur_held[7:0], data_byte};

    byte_phase_next   = cur_phase;
    in_header_next    = cur_header;
    held_bytes_next   = cur_held;
    image_height_next = cur_height;
    row_next          = cur_row;
    byte_index_next   = cur_index;
    finished_next     = cur_finished;

    push            = 1'b0;
    push_entry.cmd  = CMD_SPAN;
    push_entry.done = 1'b0;
    push_entry.b0   = cur_held[23:16];
    push_entry.b1   = cur_held[15:8];
    push_entry.b2   = cur_held[7:0];
    push_entry.b3   = data_byte;
    push_entry.row  = cur_row;

    if (cur_finished) begin
      // Bytes after completion are dropped.
    end else if (cur_phase == 2'd0 && cur_index >= INDEX_MAX) begin
      finished_next  = 1'b1;
      push           = 1'b1;
      push_entry.cmd = CMD_LIMIT;
    end else begin
      if (cur_index != INDEX_CAP) begin
        byte_index_next = cur_index + INDEX_W'(1);
      end
      if (cur_phase != 2'd3) begin
        held_bytes_next = {cur_held[15:0], data_byte};
        byte_phase_next = cur_phase + 2'd1;
      end else begin
        byte_phase_next = 2'd0;
        if (cur_header) begin
          // Header record: size of the image, row counter restarts.
          in_header_next    = 1'b0;
          image_height_next = new_height;
          row_next          = 16'd0;
          push              = 1'b1;
          push_entry.cmd    = CMD_HEADER;
          push_entry.done   = (new_height == 16'd0);
          finished_next     = (new_height == 16'd0);
        end else if (cur_held == 24'd0 && data_byte == 8'd0) begin
          // End-of-row record.
          row_next        = row_inc;
          push            = 1'b1;
          push_entry.cmd  = CMD_ROW_END;
          push_entry.done = (row_inc >= cur_height);
          finished_next   = (row_inc >= cur_height);
        end else if (data_byte != 8'd0) begin
          // Colour record with a nonzero run.
          push           = 1'b1;
          push_entry.cmd = CMD_SPAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= 2'd0;
      in_header    <= 1'b1;
      held_bytes   <= 24'd0;
      image_height <= 16'd0;
      row          <= 16'd0;
      byte_index   <= '0;
      finished     <= 1'b0;
    end else if (accept) begin
      byte_phase   <= byte_phase_next;
      in_header    <= in_header_next;
      held_bytes   <= held_bytes_next;
      image_height <= image_height_next;
      row          <= row_next;
      byte_index   <= byte_index_next;
      finished     <= finished_next;
    end
  end

endmodule

### rtl/rrsd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsd_fifo: command queue
// Small register queue between the parser and the span engine.
// ----------------------------------------------------------------------------
module rrsd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrsd_pkg::entry_t push_entry,
  input  logic             pop,
  output rrsd_pkg::entry_t head,
  output logic             empty,
  output logic             full
);
  import rrsd_pkg::*;

  entry_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (FIFO_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (FIFO_AW + 1)'(1);
      end
    end
  end

endmodule

### rtl/rrsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsd_back: span engine
// Executes queued commands: places the origin, advances the column, fades
// the colour and holds each result in the output register.
// ----------------------------------------------------------------------------
module rrsd_back (
  input  logic              clk,
  input  logic              rst,
  input  rrsd_pkg::cfg_t    cfg,
  input  rrsd_pkg::entry_t  head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic signed [17:0] span_x,
  output logic signed [17:0] span_y,
  output logic [7:0]        span_length,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);
  import rrsd_pkg::*;

  logic signed [16:0] origin_x;
  logic signed [16:0] origin_y;
  logic [15:0]        column;

  logic signed [16:0] diff_x, diff_y, adj_x, adj_y;
  logic signed [16:0] org_x_calc, org_y_calc;
  logic               slot_free;

  // Centered origin: (screen - image) / 2, rounded toward zero.
  always_comb begin
    diff_x = $signed({5'd0, cfg.screen_width}) - $signed({1'b0, head.b0, head.b1});
    diff_y = $signed({5'd0, cfg.screen_height}) - $signed({1'b0, head.b2, head.b3});
    adj_x  = diff_x + $signed({16'd0, diff_x[16]});
    adj_y  = diff_y + $signed({16'd0, diff_y[16]});
    org_x_calc = cfg.start_x[15] ? (adj_x >>> 1) : $signed({1'b0, cfg.start_x});
    org_y_calc = cfg.start_y[15] ? (adj_y >>> 1) : $signed({1'b0, cfg.start_y});
  end

  assign slot_free = !out_valid || !out_stall;
  assign pop       = slot_free && !empty;

  // Position state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      origin_x  <= '0;
      origin_y  <= '0;
      column    <= '0;
    end else begin
      if (slot_free) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        kind        <= KIND_COMPLETE;
        span_x      <= '0;
        span_y      <= '0;
        span_length <= '0;
        red         <= '0;
        green       <= '0;
        blue        <= '0;
        case (head.cmd)
          CMD_HEADER: begin
            origin_x  <= org_x_calc;
            origin_y  <= org_y_calc;
            column    <= '0;
            out_valid <= head.done;
          end
          CMD_ROW_END: begin
            column    <= '0;
            out_valid <= head.done;
          end
          CMD_SPAN: begin
            kind        <= KIND_SPAN;
            span_x      <= {origin_x[16], origin_x} + $signed({2'd0, column});
            span_y      <= {origin_y[16], origin_y} + $signed({2'd0, head.row});
            span_length <= head.b3;
            red         <= (head.b0 > cfg.fade_red)   ? head.b0 - cfg.fade_red   : 8'd0;
            green       <= (head.b1 > cfg.fade_green) ? head.b1 - cfg.fade_green : 8'd0;
            blue        <= (head.b2 > cfg.fade_blue)  ? head.b2 - cfg.fade_blue  : 8'd0;
            column      <= column + {8'd0, head.b3};
            out_valid   <= 1'b1;
          end
          CMD_LIMIT: begin
            kind      <= KIND_LIMIT;
            out_valid <= 1'b1;
          end
          default: begin
            out_valid <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

### rtl/rgb_rle_span_decoder_with_fade_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_rle_span_decoder_with_fade_top: RGB run-length span decoder with fade
// Parses an encoded image byte stream into screen spans with faded colour,
// and flags image completion and the stream byte limit.
// ----------------------------------------------------------------------------
//   Channel  | Signals                      | Moves
//   ---------+------------------------------+-----------------------------------
//   in       | in_valid / in_stall          | data_byte, new_image
//   out      | out_valid / out_stall        | kind, span_x, span_y, span_length,
//            |                              | red, green, blue
//   cfg      | cfg_write, cfg_index         | cfg_data (write only)
//
// One byte is accepted per cycle unless in_stall is high. The parser classifies
// records combinationally; the queue and then the engine register them. A
// four-entry command queue separates parser and engine, so in_stall rises only
// when the queue is full. Reset is synchronous and restores the control and
// config registers, not queue slots or results; the parser expects a header.
// ----------------------------------------------------------------------------
module rgb_rle_span_decoder_with_fade_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               new_image,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic signed [17:0] span_x,
  output logic signed [17:0] span_y,
  output logic [7:0]         span_length,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import rrsd_pkg::*;

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;
  logic   accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fade_red      <= 8'd0;
      cfg.fade_green    <= 8'd0;
      cfg.fade_blue     <= 8'd0;
      cfg.start_x       <= -16'sd1;
      cfg.start_y       <= -16'sd1;
      cfg.screen_width  <= 12'd320;
      cfg.screen_height <= 12'd240;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FADE_RED:      cfg.fade_red      <= cfg_data[7:0];
        REG_FADE_GREEN:    cfg.fade_green    <= cfg_data[7:0];
        REG_FADE_BLUE:     cfg.fade_blue     <= cfg_data[7:0];
        REG_START_X:       cfg.start_x       <= $signed(cfg_data);
        REG_START_Y:       cfg.start_y       <= $signed(cfg_data);
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  rrsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .new_image  (new_image),
    .push       (push),
    .push_entry (push_entry)
  );

  rrsd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push && accept),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  rrsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .span_x      (span_x),
    .span_y      (span_y),
    .span_length (span_length),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

endmodule
